// File: hdl/modal_resonator_bank_defines.svh
// ----------------------------------------------------------------------------
// modal_resonator_bank_defines.svh
// Assertion macros shared by the modal resonator bank RTL.
// ----------------------------------------------------------------------------
`ifndef MODAL_RESONATOR_BANK_DEFINES_SVH
`define MODAL_RESONATOR_BANK_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while in reset.
`define MRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MRB_ASSERT_NORST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRB_ASSERT(label, prop, msg)
`define MRB_ASSERT_NORST(label, prop, msg)
`endif

`endif

// File: hdl/mrb_pkg.sv
// ----------------------------------------------------------------------------
// mrb_pkg
// Widths, mode tables, codes and helpers of the modal resonator bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mrb_pkg;

	localparam int EXC_W  = 16;
	localparam int WARP_W = 16;
	localparam int COEF_W = 16;
	localparam int OUT_W  = 24;

	localparam logic [COEF_W-1:0] COEF_RESET = 16'd68;

	// shared multiplier: wide operand split in two halves
	localparam int SPLIT  = 24;
	localparam int A_W    = 48;
	localparam int B_W    = 36;
	localparam int PROD_W = SPLIT + 1 + B_W;
	localparam int FULL_W = A_W + B_W;
	localparam int RES_W  = 54;
	localparam int ACC_W  = 56;
	localparam int Y_W    = 48;
	localparam int R_W    = 32;
	localparam int COS_W  = 32;

	localparam int SH_WARP = 16;
	localparam int SH_COS  = 29;
	localparam int SH_Q32  = 32;

	// table build constants
	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q20      = 64'd3294199;
	localparam logic [63:0] WARP_SLOPE  = 64'd92;
	localparam logic [63:0] A_FLOOR     = 64'd214748365;
	localparam logic [63:0] GAIN_SCALE  = 64'd51;
	localparam logic [63:0] PAN_NEAR    = 64'd51811;
	localparam logic [63:0] PAN_FAR     = 64'd40132;

	localparam logic [15:0] FREQ_TENTHS [8] = '{
		16'd550, 16'd924, 16'd1476, 16'd2331, 16'd3888, 16'd6420, 16'd12765, 16'd24317
	};
	localparam logic [15:0] BW_TENTHS [8] = '{
		16'd60, 16'd65, 16'd70, 16'd80, 16'd90, 16'd100, 16'd120, 16'd140
	};
	localparam logic [15:0] GAIN_HUND [8] = '{
		16'd100, 16'd85, 16'd70, 16'd60, 16'd50, 16'd42, 16'd30, 16'd22
	};

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_ROM  = 7'b0000010,
		S_LO   = 7'b0000100,
		S_HI   = 7'b0001000,
		S_SUM  = 7'b0010000,
		S_WB   = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		OP_SMOOTH = 3'd0,
		OP_C1     = 3'd1,
		OP_C2     = 3'd2,
		OP_T1     = 3'd3,
		OP_T2     = 3'd4,
		OP_O      = 3'd5,
		OP_KL     = 3'd6,
		OP_KR     = 3'd7
	} op_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(8388607);
		lo = -ACC_W'(8388608);
		if (v > hi) begin
			return OUT_W'(hi);
		end else if (v < lo) begin
			return OUT_W'(lo);
		end
		return OUT_W'(v);
	endfunction

endpackage

`default_nettype wire

// File: hdl/mrb_if.sv
// ----------------------------------------------------------------------------
// mrb_if
// Valid/ready channels of the modal resonator bank: input, output, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrb_in_if import mrb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [EXC_W-1:0] excitation;
	logic [WARP_W-1:0]       warp_target;

	modport source (output valid, excitation, warp_target, input ready);
	modport sink (input valid, excitation, warp_target, output ready);
endinterface

interface mrb_out_if import mrb_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] left_out;
	logic signed [OUT_W-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface mrb_cfg_if import mrb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] smooth_coef;

	modport source (output valid, smooth_coef, input ready);
	modport sink (input valid, smooth_coef, output ready);
endinterface

`default_nettype wire

// File: hdl/modal_resonator_bank.sv
// ----------------------------------------------------------------------------
// modal_resonator_bank
// Two-pole modal resonator bank with warp-controlled damping, stereo output.
// ----------------------------------------------------------------------------
// One item in, one stereo item out. A new item is accepted only in S_IDLE,
// reached once the previous item has loaded its result into the output
// register, which raises valid for it. Every product runs through one shared
// 25x36 multiplier in two halves, followed by a rounding sum and a writeback
// step, seven products per mode plus one for warp smoothing, and one radius
// ROM read per mode. The output register lets the next item in while the
// previous result waits; a finished item stalls until that register is free.
// smooth_coef may be written at any time but is meant to change only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "modal_resonator_bank_defines.svh"

module modal_resonator_bank import mrb_pkg::*; #(
	parameter int NUM_MODES         = 8,
	parameter int SAMPLE_RATE       = 48000,
	parameter int RADIUS_TABLE_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mrb_cfg_if.sink   cfg,
	mrb_in_if.sink    din,
	mrb_out_if.source dout
);

	localparam int MW        = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
	localparam int RT_SIZE   = 1 << RADIUS_TABLE_BITS;
	localparam int ROM_DEPTH = NUM_MODES * RT_SIZE;
	localparam int AW        = MW + RADIUS_TABLE_BITS;
	localparam logic [MW-1:0] LAST_MODE = MW'(NUM_MODES - 1);
	localparam logic [127:0] SR_TENTHS = 128'(SAMPLE_RATE) * 128'd10;
	localparam logic [127:0] X_DEN     = 128'(SAMPLE_RATE) * 128'd10485760;

	// ---------------- table build (elaboration) ----------------
	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem = n;
		res = '0;
		for (int i = 0; i < 32; i++) begin
			bitv = 64'd1 << (62 - 2 * i);
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	function automatic logic [R_W-1:0] exp_neg_q32(input logic [127:0] x);
		logic [127:0]        t;
		logic signed [127:0] s;
		t = 128'd1 << 32;
		s = $signed(t);
		t = (t * x + (128'd1 << 31)) >> 32;
		s = s - $signed(t);
		t = ((t * x + (128'd2 << 31)) >> 32) / 2;
		s = s + $signed(t);
		t = ((t * x + (128'd3 << 31)) >> 32) / 3;
		s = s - $signed(t);
		t = ((t * x + (128'd4 << 31)) >> 32) / 4;
		s = s + $signed(t);
		t = ((t * x + (128'd5 << 31)) >> 32) / 5;
		s = s - $signed(t);
		t = ((t * x + (128'd6 << 31)) >> 32) / 6;
		s = s + $signed(t);
		if (s < 0) begin
			s = '0;
		end
		if (s > 128'sh0FFFFFFFF) begin
			s = 128'sh0FFFFFFFF;
		end
		return R_W'(s);
	endfunction

	function automatic logic [R_W-1:0] radius_entry(input int m, input int i);
		logic [127:0] wv;
		logic [127:0] a;
		logic [127:0] d;
		logic [127:0] x;
		wv = 128'(i) << (WARP_W - RADIUS_TABLE_BITS);
		a = (128'd1 << 32) - (128'(WARP_SLOPE) * wv * 128'd65536 + 128'd50) / 100;
		if (a < 128'(A_FLOOR)) begin
			a = 128'(A_FLOOR);
		end
		d = (a * 128'(isqrt64(64'(a << 30)))) >> 31;
		x = (d * 128'(BW_TENTHS[3'(m)]) * 128'(PI_Q20) + X_DEN / 2) / X_DEN;
		if (x == 0) begin
			x = 128'd1;
		end
		return exp_neg_q32(x);
	endfunction

	function automatic logic signed [COS_W-1:0] cos_entry(input int m);
		logic [127:0]        w;
		logic [127:0]        w2;
		logic [127:0]        t;
		logic signed [127:0] s;
		w = (128'(TWO_PI_Q30) * 128'(FREQ_TENTHS[3'(m)]) + SR_TENTHS / 2) / SR_TENTHS;
		w2 = (w * w + (128'd1 << 29)) >> 30;
		t = 128'd1 << 30;
		s = $signed(t);
		t = ((t * w2 + (128'd2 << 29)) >> 30) / 2;
		s = s - $signed(t);
		t = ((t * w2 + (128'd12 << 29)) >> 30) / 12;
		s = s + $signed(t);
		t = ((t * w2 + (128'd30 << 29)) >> 30) / 30;
		s = s - $signed(t);
		t = ((t * w2 + (128'd56 << 29)) >> 30) / 56;
		s = s + $signed(t);
		t = ((t * w2 + (128'd90 << 29)) >> 30) / 90;
		s = s - $signed(t);
		t = ((t * w2 + (128'd132 << 29)) >> 30) / 132;
		s = s + $signed(t);
		t = ((t * w2 + (128'd182 << 29)) >> 30) / 182;
		s = s - $signed(t);
		t = ((t * w2 + (128'd240 << 29)) >> 30) / 240;
		s = s + $signed(t);
		t = ((t * w2 + (128'd306 << 29)) >> 30) / 306;
		s = s - $signed(t);
		t = ((t * w2 + (128'd380 << 29)) >> 30) / 380;
		s = s + $signed(t);
		return COS_W'(s);
	endfunction

	function automatic logic signed [B_W-1:0] k_entry(input int m, input logic [63:0] pan);
		logic [127:0] k;
		k = (128'(GAIN_HUND[3'(m)]) * 128'(GAIN_SCALE) * 128'(pan) * 128'd65536 + 128'd500)
			/ 1000;
		return B_W'(k);
	endfunction

	// ---------------- constant tables ----------------
	logic [R_W-1:0]            rom_w [ROM_DEPTH];
	logic signed [COS_W-1:0]   cos_w [NUM_MODES];
	logic signed [B_W-1:0]     kl_w  [NUM_MODES];
	logic signed [B_W-1:0]     kr_w  [NUM_MODES];

	for (genvar e = 0; e < ROM_DEPTH; e++) begin : g_rom
		localparam logic [R_W-1:0] RV = radius_entry(e / RT_SIZE, e % RT_SIZE);
		assign rom_w[e] = RV;
	end

	for (genvar m = 0; m < NUM_MODES; m++) begin : g_mode
		localparam logic signed [COS_W-1:0] CV = cos_entry(m);
		localparam logic signed [B_W-1:0]   KN = k_entry(m, PAN_NEAR);
		localparam logic signed [B_W-1:0]   KF = k_entry(m, PAN_FAR);
		assign cos_w[m] = CV;
		assign kl_w[m]  = (m % 2 == 1) ? KF : KN;
		assign kr_w[m]  = (m % 2 == 1) ? KN : KF;
	end

	// ---------------- registers ----------------
	state_t                   state_q;
	op_t                      op_q;
	logic [MW-1:0]            m_q;
	logic [COEF_W-1:0]        coef_q;
	logic [WARP_W-1:0]        sw_q;
	logic                     ovalid_q;
	logic signed [Y_W-1:0]    prev_one_q [NUM_MODES];
	logic signed [Y_W-1:0]    prev_two_q [NUM_MODES];

	logic signed [EXC_W-1:0]  x_q;
	logic [WARP_W-1:0]        tgt_q;
	logic [R_W-1:0]           r_q;
	logic signed [PROD_W-1:0] p_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [RES_W-1:0]  res_q;
	logic signed [B_W-1:0]    c1_q;
	logic signed [B_W-1:0]    c2_q;
	logic signed [RES_W-1:0]  t1_q;
	logic signed [Y_W-1:0]    o_q;
	logic signed [ACC_W-1:0]  accl_q;
	logic signed [ACC_W-1:0]  accr_q;
	logic signed [OUT_W-1:0]  lout_q;
	logic signed [OUT_W-1:0]  rout_q;

	// ---------------- shared multiply unit ----------------
	logic [AW-1:0]            rom_addr;
	logic signed [WARP_W:0]   delta;
	logic [R_W:0]             g_w;
	logic signed [A_W-1:0]    a_op;
	logic signed [B_W-1:0]    b_op;
	logic signed [SPLIT:0]    mul_a;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [FULL_W-1:0] lo_ext;
	logic signed [FULL_W-1:0] hi_ext;
	logic signed [FULL_W-1:0] rnd;
	logic signed [FULL_W-1:0] sum_full;
	logic signed [RES_W-1:0]  res_w;
	logic signed [RES_W-1:0]  y_sum;
	logic signed [Y_W-1:0]    y_sat;
	logic                     out_load;

	assign rom_addr = {m_q, sw_q[WARP_W-1 -: RADIUS_TABLE_BITS]};
	assign delta    = $signed({1'b0, tgt_q}) - $signed({1'b0, sw_q});
	assign g_w      = {1'b1, {R_W{1'b0}}} - {1'b0, r_q};

	always_comb begin
		unique case (op_q)
			OP_SMOOTH: begin
				a_op = {{(A_W-WARP_W-1){delta[WARP_W]}}, delta};
				b_op = {{(B_W-COEF_W){1'b0}}, coef_q};
			end
			OP_C1: begin
				a_op = {{(A_W-R_W){1'b0}}, r_q};
				b_op = {{(B_W-COS_W){cos_w[m_q][COS_W-1]}}, cos_w[m_q]};
			end
			OP_C2: begin
				a_op = {{(A_W-R_W){1'b0}}, r_q};
				b_op = {{(B_W-R_W){1'b0}}, r_q};
			end
			OP_T1: begin
				a_op = prev_one_q[m_q];
				b_op = c1_q;
			end
			OP_T2: begin
				a_op = prev_two_q[m_q];
				b_op = c2_q;
			end
			OP_O: begin
				a_op = prev_one_q[m_q];
				b_op = {{(B_W-R_W-1){1'b0}}, g_w};
			end
			OP_KL: begin
				a_op = o_q;
				b_op = kl_w[m_q];
			end
			OP_KR: begin
				a_op = o_q;
				b_op = kr_w[m_q];
			end
		endcase
	end

	assign mul_a = (state_q == S_HI) ? {a_op[A_W-1], a_op[A_W-1:SPLIT]}
		: {1'b0, a_op[SPLIT-1:0]};
	assign mul_p = mul_a * b_op;

	assign lo_ext   = {{(FULL_W-PROD_W){acc_q[PROD_W-1]}}, acc_q};
	assign hi_ext   = {p_q[FULL_W-SPLIT-1:0], {SPLIT{1'b0}}};
	assign sum_full = lo_ext + hi_ext + rnd;

	always_comb begin
		unique case (op_q)
			OP_SMOOTH: rnd = FULL_W'(1) <<< (SH_WARP - 1);
			OP_C1:     rnd = FULL_W'(1) <<< (SH_COS - 1);
			default:   rnd = FULL_W'(1) <<< (SH_Q32 - 1);
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_SMOOTH: res_w = RES_W'(sum_full >>> SH_WARP);
			OP_C1:     res_w = RES_W'(sum_full >>> SH_COS);
			default:   res_w = RES_W'(sum_full >>> SH_Q32);
		endcase
	end

	// y = c1 y1 - c2 y2 + 256 x, saturated
	assign y_sum = t1_q - res_q + $signed({{(RES_W-EXC_W-8){x_q[EXC_W-1]}}, x_q, 8'd0});

	always_comb begin
		if (y_sum > $signed({{(RES_W-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}})) begin
			y_sat = {1'b0, {(Y_W-1){1'b1}}};
		end else if (y_sum < $signed({{(RES_W-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}})) begin
			y_sat = {1'b1, {(Y_W-1){1'b0}}};
		end else begin
			y_sat = Y_W'(y_sum);
		end
	end

	assign out_load = (state_q == S_DONE) && (!ovalid_q || dout.ready);

	// ---------------- sequencer and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_SMOOTH;
			m_q      <= '0;
			coef_q   <= COEF_RESET;
			sw_q     <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < NUM_MODES; i++) begin
				prev_one_q[i] <= '0;
				prev_two_q[i] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				coef_q <= cfg.smooth_coef;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						state_q <= S_LO;
						op_q    <= OP_SMOOTH;
					end
				end
				S_ROM: state_q <= S_LO;
				S_LO:  state_q <= S_HI;
				S_HI:  state_q <= S_SUM;
				S_SUM: state_q <= S_WB;
				S_WB: begin
					unique case (op_q)
						OP_SMOOTH: begin
							sw_q    <= sw_q + res_q[WARP_W-1:0];
							m_q     <= '0;
							op_q    <= OP_C1;
							state_q <= S_ROM;
						end
						OP_C1: begin
							op_q    <= OP_C2;
							state_q <= S_LO;
						end
						OP_C2: begin
							op_q    <= OP_T1;
							state_q <= S_LO;
						end
						OP_T1: begin
							op_q    <= OP_T2;
							state_q <= S_LO;
						end
						OP_T2: begin
							prev_two_q[m_q] <= prev_one_q[m_q];
							prev_one_q[m_q] <= y_sat;
							op_q            <= OP_O;
							state_q         <= S_LO;
						end
						OP_O: begin
							op_q    <= OP_KL;
							state_q <= S_LO;
						end
						OP_KL: begin
							op_q    <= OP_KR;
							state_q <= S_LO;
						end
						OP_KR: begin
							op_q <= OP_C1;
							if (m_q == LAST_MODE) begin
								state_q <= S_DONE;
							end else begin
								m_q     <= m_q + MW'(1);
								state_q <= S_ROM;
							end
						end
					endcase
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		r_q <= rom_w[rom_addr];
		if (state_q == S_IDLE && din.valid) begin
			x_q    <= din.excitation;
			tgt_q  <= din.warp_target;
			accl_q <= '0;
			accr_q <= '0;
		end
		if (state_q == S_LO) begin
			p_q <= mul_p;
		end
		if (state_q == S_HI) begin
			acc_q <= p_q;
			p_q   <= mul_p;
		end
		if (state_q == S_SUM) begin
			res_q <= res_w;
		end
		if (state_q == S_WB) begin
			case (op_q)
				OP_C1:   c1_q   <= res_q[B_W-1:0];
				OP_C2:   c2_q   <= res_q[B_W-1:0];
				OP_T1:   t1_q   <= res_q;
				OP_O:    o_q    <= res_q[Y_W-1:0];
				OP_KL:   accl_q <= accl_q + ACC_W'(res_q);
				OP_KR:   accr_q <= accr_q + ACC_W'(res_q);
				default: ;
			endcase
		end
		if (out_load) begin
			lout_q <= sat_out(accl_q);
			rout_q <= sat_out(accr_q);
		end
	end

	assign cfg.ready      = 1'b1;
	assign din.ready      = (state_q == S_IDLE);
	assign dout.valid     = ovalid_q;
	assign dout.left_out  = lout_q;
	assign dout.right_out = rout_q;

	// ---------------- assertions ----------------
	`MRB_ASSERT(a_mode_range, m_q <= LAST_MODE, "mode counter out of range")
	`MRB_ASSERT(a_smooth_toward, (state_q == S_WB && op_q == OP_SMOOTH) |=> ((sw_q >= $past(sw_q) && sw_q <= $past(tgt_q)) || (sw_q <= $past(sw_q) && sw_q >= $past(tgt_q))), "smoothed warp left old-target span")
	`MRB_ASSERT(a_done_load, out_load |=> (state_q == S_IDLE && ovalid_q), "result not loaded on done")
	`MRB_ASSERT(a_valid_src, $rose(ovalid_q) |-> $past(state_q == S_DONE), "output valid without done")

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the eight-mode modal resonator bank.
// Drives excitation/warp items with random idle on both channels and checks
// every stereo result against a bit-exact fixed-point model of the bank that
// is kept in this bench, or against a fixed value for the known rows. The
// smoothing coefficient is rewritten between phases while the bank is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import mrb_pkg::*;

	localparam int MODES     = 8;
	localparam int RATE_HZ   = 48000;
	localparam int ROM_BITS  = 8;
	localparam int ROM_DEPTH = 1 << ROM_BITS;

	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 155;

	localparam logic [15:0] COEF_AT_RESET = 16'd68;
	localparam logic [15:0] COEF_PLAN [PHASES] = '{
		16'hFFFF, 16'h0000, 16'h0001, 16'd68, 16'h8000, 16'h0000, 16'h0000, 16'hFFFF
	};

	localparam longint Y_TOP    = 64'sd140737488355327;
	localparam longint Y_BOTTOM = -Y_TOP - 1;
	localparam longint OUT_TOP  = 64'sd8388607;
	localparam longint OUT_BOT  = -64'sd8388608;

	localparam longint unsigned HZ_TENTHS [8] = '{550, 924, 1476, 2331, 3888, 6420, 12765, 24317};
	localparam longint unsigned BW_TENTHS_T [8] = '{60, 65, 70, 80, 90, 100, 120, 140};
	localparam longint unsigned GAIN_PCT [8] = '{100, 85, 70, 60, 50, 42, 30, 22};

	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
	} stereo_t;

	typedef struct {
		logic signed [EXC_W-1:0] exc;
		logic [WARP_W-1:0]       warp;
		bit                      known;
		stereo_t                 typed;
	} drive_row_t;

	// zero drive from the reset state stays silent whatever the warp does
	localparam int DIRECTED_N = 15;
	drive_row_t directed_rows [DIRECTED_N] = '{
		'{16'sh0000, 16'h0000, 1'b1, '0},
		'{16'sh0000, 16'hFFFF, 1'b1, '0},
		'{16'sh0000, 16'h8000, 1'b1, '0},
		'{16'sh7FFF, 16'hFFFF, 1'b0, '0},
		'{16'sh8000, 16'hFFFF, 1'b0, '0},
		'{16'sh0001, 16'h0000, 1'b0, '0},
		'{16'shFFFF, 16'hFFFE, 1'b0, '0},
		'{16'sh5555, 16'hAAAA, 1'b0, '0},
		'{16'shAAAA, 16'h5555, 1'b0, '0},
		'{16'sh8000, 16'h0000, 1'b0, '0},
		'{16'sh7FFF, 16'h0001, 1'b0, '0},
		'{16'sh0000, 16'h0000, 1'b0, '0},
		'{16'sh0000, 16'hFFFF, 1'b0, '0},
		'{16'sh0000, 16'h0000, 1'b0, '0},
		'{16'sh0000, 16'h7FFF, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	mrb_in_if  din_ch ();
	mrb_out_if dout_ch ();
	mrb_cfg_if cfg_ch ();

	modal_resonator_bank #(
		.NUM_MODES(MODES),
		.SAMPLE_RATE(RATE_HZ),
		.RADIUS_TABLE_BITS(ROM_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.din(din_ch),
		.dout(dout_ch)
	);

	// bank model state
	longint unsigned pole_radius [MODES][ROM_DEPTH];
	longint          mode_cos [MODES];
	longint          pan_left [MODES];
	longint          pan_right [MODES];
	logic [15:0]     warp_coef;
	logic [15:0]     warp_smooth;
	longint          y_one [MODES];
	longint          y_two [MODES];

	stereo_t stereo_due [$];
	int      fails;
	int      samples_sent;
	int      results_seen;
	int      clipped;
	int      quiet;
	bit      steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned decay_q32(input longint unsigned x);
		longint unsigned term;
		longint unsigned dv;
		longint          sum;
		int              k;
		term = 64'd1 << 32;
		sum = longint'(term);
		for (k = 1; k <= 6; k++) begin
			dv = 64'(k) << 32;
			term = (term * x + dv / 2) / dv;
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		if (sum < 0)
			sum = 0;
		if (sum > 64'sh00000000FFFFFFFF)
			sum = 64'sh00000000FFFFFFFF;
		return longint'(sum);
	endfunction

	function automatic longint cos_q30(input longint unsigned w);
		longint unsigned w2;
		longint unsigned term;
		longint unsigned dv;
		longint          sum;
		int              k;
		w2 = (w * w + (64'd1 << 29)) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (k = 1; k <= 10; k++) begin
			dv = 64'((2 * k - 1) * (2 * k)) << 30;
			term = (term * w2 + dv / 2) / dv;
			if (k % 2 == 1)
				sum -= longint'(term);
			else
				sum += longint'(term);
		end
		return sum;
	endfunction

	function automatic void build_mode_tables();
		longint unsigned sr;
		longint unsigned w;
		longint unsigned kn;
		longint unsigned kf;
		longint unsigned wv;
		longint unsigned a;
		longint unsigned d;
		longint unsigned den;
		longint unsigned x;
		int              m;
		int              i;
		int              t;
		sr = RATE_HZ;
		for (m = 0; m < MODES; m++) begin
			t = m % 8;
			w = (64'd6746518852 * HZ_TENTHS[t] + 5 * sr) / (10 * sr);
			kn = (GAIN_PCT[t] * 64'd51 * 64'd51811 * 64'd65536 + 500) / 1000;
			kf = (GAIN_PCT[t] * 64'd51 * 64'd40132 * 64'd65536 + 500) / 1000;
			mode_cos[m] = cos_q30(w);
			pan_left[m] = longint'((m % 2 == 1) ? kf : kn);
			pan_right[m] = longint'((m % 2 == 1) ? kn : kf);
			for (i = 0; i < ROM_DEPTH; i++) begin
				wv = 64'(i) << (16 - ROM_BITS);
				a = (64'd1 << 32) - (92 * wv * 65536 + 50) / 100;
				if (a < 64'd214748365)
					a = 64'd214748365;
				d = (a * root_floor(a << 30)) >> 31;
				den = 10 * sr * 64'd1048576;
				x = (d * BW_TENTHS_T[t] * 64'd3294199 + den / 2) / den;
				if (x == 0)
					x = 1;
				pole_radius[m][i] = decay_q32(x);
			end
		end
	endfunction

	// floor((a * b + 2^31) / 2^32)
	function automatic longint q32_mul(input longint a, input longint b);
		logic signed [127:0] pa;
		logic signed [127:0] pb;
		logic signed [127:0] p;
		pa = a;
		pb = b;
		p = (pa * pb + (128'sd1 <<< 31)) >>> 32;
		return longint'(p);
	endfunction

	function automatic logic signed [OUT_W-1:0] clip24(input longint v);
		if (v > OUT_TOP)
			v = OUT_TOP;
		if (v < OUT_BOT)
			v = OUT_BOT;
		return OUT_W'(v);
	endfunction

	function automatic stereo_t resonate(input logic signed [EXC_W-1:0] x,
			input logic [WARP_W-1:0] w);
		longint          step;
		longint unsigned r;
		longint          c1;
		longint          c2;
		longint          g;
		longint          y;
		longint          o;
		longint          acc_l;
		longint          acc_r;
		int              idx;
		int              m;
		stereo_t         res;
		step = (longint'(warp_coef) * (longint'(w) - longint'(warp_smooth)) + 32768) >>> 16;
		warp_smooth = 16'(longint'(warp_smooth) + step);
		idx = int'(warp_smooth >> (16 - ROM_BITS));
		acc_l = 0;
		acc_r = 0;
		for (m = 0; m < MODES; m++) begin
			r = pole_radius[m][idx];
			c1 = (mode_cos[m] * longint'(r) + (64'sd1 <<< 28)) >>> 29;
			c2 = longint'((r * r + (64'd1 << 31)) >> 32);
			g = (64'sd1 <<< 32) - longint'(r);
			y = q32_mul(y_one[m], c1) - q32_mul(y_two[m], c2) + longint'(x) * 256;
			if (y > Y_TOP)
				y = Y_TOP;
			if (y < Y_BOTTOM)
				y = Y_BOTTOM;
			y_two[m] = y_one[m];
			y_one[m] = y;
			o = q32_mul(y, g);
			acc_l += q32_mul(o, pan_left[m]);
			acc_r += q32_mul(o, pan_right[m]);
		end
		res.left = clip24(acc_l);
		res.right = clip24(acc_r);
		return res;
	endfunction

	function automatic int idle_cycles();
		int p;
		if (steady)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic play_sample(input logic signed [EXC_W-1:0] x, input logic [WARP_W-1:0] w,
			input bit known = 1'b0, input stereo_t typed = '0);
		int      gap;
		stereo_t predicted;
		gap = idle_cycles();
		if (gap > 0) begin
			din_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.excitation <= x;
		din_ch.warp_target <= w;
		@(posedge clk);
		while (!din_ch.ready)
			@(posedge clk);
		predicted = resonate(x, w);
		stereo_due.push_back(known ? typed : predicted);
		samples_sent++;
	endtask

	task automatic settle();
		din_ch.valid <= 1'b0;
		while (stereo_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_coef(input logic [COEF_W-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.smooth_coef <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		warp_coef = v;
	endtask

	// result side: random back-pressure
	initial begin
		int stall;
		stall = 0;
		dout_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				dout_ch.ready <= 1'b0;
			end else begin
				dout_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall = idle_cycles();
			end
		end
	end

	always @(posedge clk) begin
		stereo_t want;
		if (!arst_n) begin
			quiet <= 0;
		end else if ((din_ch.valid && din_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
				(dout_ch.valid && dout_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			results_seen++;
			if (stereo_due.size() == 0) begin
				fails++;
				$display("%0t: unexpected result left %0d right %0d", $time,
					dout_ch.left_out, dout_ch.right_out);
			end else begin
				want = stereo_due.pop_front();
				if (want.left == 24'sh7FFFFF || want.left == 24'sh800000 ||
						want.right == 24'sh7FFFFF || want.right == 24'sh800000)
					clipped++;
				if (dout_ch.left_out !== want.left) begin
					fails++;
					$display("%0t: left_out expected %0d got %0d", $time, want.left,
						dout_ch.left_out);
				end
				if (dout_ch.right_out !== want.right) begin
					fails++;
					$display("%0t: right_out expected %0d got %0d", $time, want.right,
						dout_ch.right_out);
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
			QUIET_LIMIT, stereo_due.size());
		$display("modal_resonator_bank regression: fail");
		$finish;
	end

	initial begin
		int                      p;
		int                      j;
		int                      items;
		int                      seg_len;
		int                      half;
		int                      m;
		logic [COEF_W-1:0]       coef;
		logic [WARP_W-1:0]       w;
		logic signed [EXC_W-1:0] x;

		fails = 0;
		samples_sent = 0;
		results_seen = 0;
		clipped = 0;
		steady = 1'b0;
		build_mode_tables();
		warp_coef = COEF_AT_RESET;
		warp_smooth = '0;
		for (m = 0; m < MODES; m++) begin
			y_one[m] = 0;
			y_two[m] = 0;
		end

		arst_n = 1'b0;
		din_ch.valid = 1'b0;
		din_ch.excitation = '0;
		din_ch.warp_target = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.smooth_coef = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (j = 0; j < DIRECTED_N; j++)
			play_sample(directed_rows[j].exc, directed_rows[j].warp,
				directed_rows[j].known, directed_rows[j].typed);
		settle();

		for (p = 0; p < PHASES; p++) begin
			steady = (p == 3 || p == 6);
			coef = (p == 5 || p == 6) ? 16'($urandom) : COEF_PLAN[p];
			write_coef(coef);
			items = 0;
			while (items < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						seg_len = $urandom_range(5, 40);
						repeat (seg_len)
							play_sample(16'($urandom), 16'($urandom));
					end
					4, 5: begin
						// held full-scale drive, pushes the sums into clipping
						seg_len = $urandom_range(30, 120);
						x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
						w = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
						repeat (seg_len)
							play_sample(x, w);
					end
					6: begin
						seg_len = $urandom_range(100, 300);
						half = $urandom_range(5, 220);
						w = 16'($urandom);
						for (j = 0; j < seg_len; j++)
							play_sample(((j / half) % 2 == 1) ? 16'sh8000 : 16'sh7FFF, w);
					end
					7: begin
						seg_len = $urandom_range(20, 80);
						w = 16'($urandom);
						play_sample($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, w);
						repeat (seg_len - 1)
							play_sample(16'sh0000, w);
					end
					8: begin
						seg_len = $urandom_range(20, 60);
						for (j = 0; j < seg_len; j++)
							play_sample(16'($signed($urandom_range(0, 2047)) - 1024),
								16'((j * 65535) / (seg_len - 1)));
					end
					default: begin
						seg_len = $urandom_range(10, 40);
						for (j = 0; j < seg_len; j++)
							play_sample(16'($urandom), (j % 2 == 1) ? 16'hFFFF : 16'h0000);
					end
				endcase
				items += seg_len;
			end
			settle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("%0d samples over %0d coefficient settings, %0d results checked",
			samples_sent, PHASES + 1, results_seen);
		$display("%0d results at the output clip limit", clipped);
		if (fails == 0 && stereo_due.size() == 0) begin
			$display("modal_resonator_bank regression: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", fails, stereo_due.size());
			$display("modal_resonator_bank regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
